// ----- src/tte_pkg.sv -----
// shared types and constants of the tap tempo estimator
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  localparam int HISTORY_TAPS_DEF = 5;
  localparam int BEAT_MS          = 60000;

  localparam int TAP_W      = 32;
  localparam int GAP_W      = 16;
  localparam int BPM_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAP_W-1:0] GAP_LIMIT_RST = 16'd2000;
  localparam logic [BPM_W-1:0] MIN_BPM_RST   = 8'd40;
  localparam logic [BPM_W-1:0] MAX_BPM_RST   = 8'd240;
  localparam logic [BPM_W-1:0] TEMPO_RST     = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_LIMIT = 2'd0,
    CFG_MIN_BPM   = 2'd1,
    CFG_MAX_BPM   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SETUP = 2'd1,
    ST_DIV   = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic accept;
    logic setup;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic few_taps;
    logic total_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/tte_ctrl.sv -----
// controller state machine of the tap tempo estimator
`timescale 1ns / 1ps
`default_nettype none

module tte_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output tte_pkg::cmd_t     cmd_o,
  input  wire tte_pkg::sts_t sts_i
);

  tte_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tte_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tte_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tte_pkg::ST_SETUP;
      end
      tte_pkg::ST_SETUP: begin
        if (sts_i.few_taps || sts_i.total_zero) state_d = tte_pkg::ST_DONE;
        else state_d = tte_pkg::ST_DIV;
      end
      tte_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = tte_pkg::ST_DONE;
      end
      tte_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = tte_pkg::ST_IDLE;
      end
      default: state_d = tte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      tte_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      tte_pkg::ST_SETUP: cmd_o.setup = 1'b1;
      tte_pkg::ST_DIV:   cmd_o.step = 1'b1;
      tte_pkg::ST_DONE:  cmd_o.load_out = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_div_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tte_pkg::ST_DIV && sts_i.div_last) |=> (state_q == tte_pkg::ST_DONE))
    else $error("divider finished without moving to result");

  a_accept_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == tte_pkg::ST_SETUP))
    else $error("accepted tap did not start setup");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tte_pkg::ST_DONE && !sts_i.out_free) |=> (state_q == tte_pkg::ST_DONE))
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ----- src/tte_dpath.sv -----
// configuration and history registers, iterative divider, clamp and output register
`timescale 1ns / 1ps
`default_nettype none

module tte_dpath #(
  parameter int HISTORY_TAPS = tte_pkg::HISTORY_TAPS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tte_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [tte_pkg::TAP_W-1:0]      tap_time_ms_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [tte_pkg::BPM_W-1:0]           tempo_bpm_o,
  output logic                                tempo_updated_o,
  input  wire tte_pkg::cmd_t                  cmd_i,
  output tte_pkg::sts_t                       sts_o
);

  localparam int CntW  = $clog2(HISTORY_TAPS + 1);
  localparam int IdxW  = $clog2(HISTORY_TAPS);
  localparam int NumW  = $clog2(tte_pkg::BEAT_MS * (HISTORY_TAPS - 1) + 1);
  localparam int StepW = $clog2(NumW);
  localparam int TapW  = tte_pkg::TAP_W;
  localparam int BpmW  = tte_pkg::BPM_W;

  // configuration
  logic [tte_pkg::GAP_W-1:0] gap_limit_q;
  logic [BpmW-1:0]           min_bpm_q;
  logic [BpmW-1:0]           max_bpm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= tte_pkg::GAP_LIMIT_RST;
      min_bpm_q   <= tte_pkg::MIN_BPM_RST;
      max_bpm_q   <= tte_pkg::MAX_BPM_RST;
    end else if (cfg_valid_i) begin
      case (tte_pkg::cfg_idx_e'(cfg_index_i))
        tte_pkg::CFG_GAP_LIMIT: gap_limit_q <= cfg_data_i;
        tte_pkg::CFG_MIN_BPM:   min_bpm_q   <= cfg_data_i[BpmW-1:0];
        tte_pkg::CFG_MAX_BPM:   max_bpm_q   <= cfg_data_i[BpmW-1:0];
        default: begin
          gap_limit_q <= gap_limit_q;
        end
      endcase
    end
  end

  // tap history, oldest at entry zero
  logic [TapW-1:0] hist_q [HISTORY_TAPS];
  logic [TapW-1:0] newest_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_eff;
  logic [TapW-1:0] gap;
  logic            full;

  assign gap       = tap_time_ms_i - newest_q;
  assign count_eff = (count_q != '0 && gap > TapW'(gap_limit_q)) ? '0 : count_q;
  assign full      = (count_eff == CntW'(HISTORY_TAPS));
  assign count_d   = full ? count_eff : count_eff + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) newest_q <= tap_time_ms_i;
  end

  for (genvar g = 0; g < HISTORY_TAPS; g++) begin : g_hist
    if (g < HISTORY_TAPS - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (cmd_i.accept) begin
          if (full) hist_q[g] <= hist_q[g+1];
          else if (count_eff[IdxW-1:0] == IdxW'(g)) hist_q[g] <= tap_time_ms_i;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (cmd_i.accept) begin
          if (full || count_eff[IdxW-1:0] == IdxW'(g)) hist_q[g] <= tap_time_ms_i;
        end
      end
    end
  end

  // setup
  logic [TapW-1:0] total;
  logic [CntW-1:0] cnt_minus1;
  logic [NumW-1:0] numer;

  assign total      = newest_q - hist_q[0];
  assign cnt_minus1 = count_q - CntW'(1);
  assign numer      = NumW'(tte_pkg::BEAT_MS) * NumW'(cnt_minus1);

  // restoring divider, one quotient bit per cycle
  logic [TapW-1:0]  den_q;
  logic [TapW-1:0]  rem_q;
  logic [NumW-1:0]  quo_q;
  logic [StepW-1:0] step_q;
  logic             hold_q;
  logic             sat_q;
  logic [TapW:0]    trial;
  logic [TapW:0]    diff;
  logic             qbit;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      den_q  <= total;
      rem_q  <= '0;
      quo_q  <= numer;
      step_q <= '0;
      hold_q <= sts_o.few_taps;
      sat_q  <= sts_o.total_zero;
    end else if (cmd_i.step) begin
      rem_q  <= qbit ? diff[TapW-1:0] : trial[TapW-1:0];
      quo_q  <= {quo_q[NumW-2:0], qbit};
      step_q <= step_q + StepW'(1);
    end
  end

  // clamp and result
  logic [BpmW-1:0] upper;
  logic [BpmW-1:0] clamped;
  logic [BpmW-1:0] tempo_res;
  logic [BpmW-1:0] last_tempo_q;

  assign upper     = (sat_q || quo_q > NumW'(max_bpm_q)) ? max_bpm_q : quo_q[BpmW-1:0];
  assign clamped   = (upper < min_bpm_q) ? min_bpm_q : upper;
  assign tempo_res = hold_q ? last_tempo_q : clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tempo_q <= tte_pkg::TEMPO_RST;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.load_out) begin
        last_tempo_q <= tempo_res;
        out_valid_o  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      tempo_bpm_o     <= tempo_res;
      tempo_updated_o <= !hold_q;
    end
  end

  assign sts_o.few_taps   = (count_q < CntW'(2));
  assign sts_o.total_zero = (total == '0);
  assign sts_o.div_last   = (step_q == StepW'(NumW - 1));
  assign sts_o.out_free   = !out_valid_o || out_ready_i;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(HISTORY_TAPS))
    else $error("tap count beyond history depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over a pending request");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  a_setup_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (count_q != '0))
    else $error("accepted tap left history empty");

endmodule

`default_nettype wire

// ----- src/tap_tempo_estimator_unit.sv -----
// top level of the tap tempo estimator
//
//  channel   direction  signals                                   payload
//  cfg       in         cfg_valid_i / cfg_ready_o                 cfg_index_i, cfg_data_i
//  in        in         in_valid_i / in_ready_o                   tap_time_ms_i
//  out       out        out_valid_o / out_ready_i                 tempo_bpm_o, tempo_updated_o
//
// with fewer than two taps or a zero span a tap goes from setup straight to the result,
// otherwise the bit-serial divider runs first, one quotient bit per step, NumW being
// its quotient width (18 for five taps)
// the next tap is taken as soon as the previous result sits in the output register
// a stalled output holds one result and the controller waits before loading the next
// reset clears the history count, sets the tempo to 120 and the registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module tap_tempo_estimator_unit #(
  parameter int HISTORY_TAPS = tte_pkg::HISTORY_TAPS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tte_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [tte_pkg::TAP_W-1:0]      tap_time_ms_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [tte_pkg::BPM_W-1:0]           tempo_bpm_o,
  output logic                                tempo_updated_o
);

  tte_pkg::cmd_t cmd;
  tte_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tte_dpath #(
    .HISTORY_TAPS (HISTORY_TAPS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .tap_time_ms_i   (tap_time_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tempo_bpm_o     (tempo_bpm_o),
    .tempo_updated_o (tempo_updated_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tte_checker.sv -----
// tempo predictor and result checker for the tap tempo estimator testbench
`timescale 1ns / 1ps

module tte_checker
  import tte_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [TAP_W-1:0]      tap_time_ms_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [BPM_W-1:0]      tempo_bpm_i,
  input  logic                  tempo_updated_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [BPM_W-1:0] bpm;
    logic             updated;
  } tempo_t;

  logic [TAP_W-1:0] taps_q [HISTORY_TAPS_DEF];
  int unsigned      n_taps;
  logic [BPM_W-1:0] tempo_q;
  logic [GAP_W-1:0] gap_limit_q;
  logic [BPM_W-1:0] min_bpm_q;
  logic [BPM_W-1:0] max_bpm_q;
  tempo_t           tempo_exp_q [$];

  task automatic track_tap(input logic [TAP_W-1:0] t, output tempo_t res);
    logic [TAP_W-1:0] gap;
    logic [TAP_W-1:0] span;
    longint unsigned  bpm;
    res.updated = 1'b0;
    if (n_taps > 0) begin
      gap = t - taps_q[n_taps-1];
      if (gap > {16'd0, gap_limit_q}) n_taps = 0;
    end
    if (n_taps >= HISTORY_TAPS_DEF) begin
      for (int i = 1; i < HISTORY_TAPS_DEF; i++) taps_q[i-1] = taps_q[i];
      taps_q[HISTORY_TAPS_DEF-1] = t;
    end else begin
      taps_q[n_taps] = t;
      n_taps++;
    end
    if (n_taps >= 2) begin
      span = t - taps_q[0];
      if (span == '0) begin
        bpm = '1;
      end else begin
        bpm = (64'(BEAT_MS) * 64'(n_taps - 1)) / 64'(span);
      end
      if (bpm > 64'(max_bpm_q)) bpm = 64'(max_bpm_q);
      if (bpm < 64'(min_bpm_q)) bpm = 64'(min_bpm_q);
      tempo_q = bpm[BPM_W-1:0];
      res.updated = 1'b1;
    end
    res.bpm = tempo_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tempo_t res;
    tempo_t exp_res;
    if (!rst_ni) begin
      n_taps       = 0;
      tempo_q      = TEMPO_RST;
      gap_limit_q  = GAP_LIMIT_RST;
      min_bpm_q    = MIN_BPM_RST;
      max_bpm_q    = MAX_BPM_RST;
      tempo_exp_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GAP_LIMIT: gap_limit_q = cfg_data_i[GAP_W-1:0];
          CFG_MIN_BPM:   min_bpm_q   = cfg_data_i[BPM_W-1:0];
          CFG_MAX_BPM:   max_bpm_q   = cfg_data_i[BPM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        track_tap(tap_time_ms_i, res);
        tempo_exp_q = {tempo_exp_q, res};
      end
      if (out_valid_i && out_ready_i) begin
        if (tempo_exp_q.size() == 0) begin
          $error("unexpected tempo result: tempo_bpm %0d tempo_updated %0d",
                 tempo_bpm_i, tempo_updated_i);
          fail_count_o++;
        end else begin
          exp_res = tempo_exp_q.pop_front();
          if (tempo_bpm_i !== exp_res.bpm) begin
            $error("tempo_bpm: expected %0d, got %0d", exp_res.bpm, tempo_bpm_i);
            fail_count_o++;
          end
          if (tempo_updated_i !== exp_res.updated) begin
            $error("tempo_updated: expected %0d, got %0d", exp_res.updated, tempo_updated_i);
            fail_count_o++;
          end
        end
      end
      pending_o = tempo_exp_q.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top: tap and register stimulus, output stalls and final verdict
`timescale 1ns / 1ps

module tb;
  import tte_pkg::*;

  localparam int                   N_PHASES       = 12;
  localparam int                   TAPS_PER_PHASE = 117;
  localparam int                   DRAIN_CYCLES   = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = CFG_GAP_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [TAP_W-1:0]      tap_time_ms_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [BPM_W-1:0]      tempo_bpm_o;
  logic                  tempo_updated_o;

  int                    fail_count;
  int                    pending;
  logic                  in_idle         = 1'b1;
  logic                  out_idle        = 1'b1;
  logic [GAP_W-1:0]      cur_gap         = GAP_LIMIT_RST;

  always #5 clk_i = ~clk_i;

  tap_tempo_estimator_unit u_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .tap_time_ms_i,
    .out_valid_o,
    .out_ready_i,
    .tempo_bpm_o,
    .tempo_updated_o
  );

  tte_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .tap_time_ms_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .tempo_bpm_i     (tempo_bpm_o),
    .tempo_updated_i (tempo_updated_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  task automatic drive_tap(input logic [TAP_W-1:0] t);
    int n;
    n = in_idle ? $urandom_range(11, 0) : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    tap_time_ms_i <= t;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
  endtask

  // bpm registers carry random upper bits that must be dropped
  task automatic set_config(input logic [GAP_W-1:0] gap, input logic [BPM_W-1:0] lo,
                            input logic [BPM_W-1:0] hi, input logic spare);
    write_reg(CFG_GAP_LIMIT, gap);
    if (spare) write_reg(CFG_SPARE, 16'($urandom));
    write_reg(CFG_MIN_BPM, {8'($urandom), lo});
    write_reg(CFG_MAX_BPM, {8'($urandom), hi});
    cfg_valid_i <= 1'b0;
    cur_gap = gap;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [TAP_W-1:0] tap_step();
    int r;
    int hi;
    r  = $urandom_range(9, 0);
    hi = (cur_gap > 1500) ? 1500 : cur_gap;
    case (r)
      0:       return TAP_W'($urandom_range(3, 0));
      1:       return TAP_W'(cur_gap) + TAP_W'($urandom_range(50, 1));
      2, 3, 4: return TAP_W'($urandom_range(cur_gap, 0));
      default: return TAP_W'($urandom_range(hi, (hi > 250) ? 250 : 0));
    endcase
  endfunction

  // receiver side stalls
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = out_idle ? $urandom_range(11, 0) : 0;
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin
    logic [TAP_W-1:0] t;
    logic [GAP_W-1:0] gap;
    logic [BPM_W-1:0] lo;
    logic [BPM_W-1:0] hi;
    int               sent;
    int               burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: fill and shift the history, gap clear, zero span, wrap
    drive_tap(32'd0);
    drive_tap(32'd500);
    drive_tap(32'd1000);
    drive_tap(32'd1000);
    drive_tap(32'd1500);
    drive_tap(32'd2000);
    drive_tap(32'd2600);
    drive_tap(32'd5000);
    drive_tap(32'd7000);
    drive_tap(32'd20000);
    drive_tap(32'd20000);
    drive_tap(32'hFFFF_FF00);
    drive_tap(32'h0000_0064);
    drive_tap(32'hFFFF_FFFF);
    drive_tap(32'h0000_0000);
    drain();

    // widest gap, min of zero, max at top
    set_config(16'hFFFF, 8'd0, 8'd255, 1'b1);
    drive_tap(32'h8000_0000);
    drive_tap(32'h8000_FFFF);
    drive_tap(32'h8001_0000);
    drive_tap(32'h8001_0000);
    drive_tap(32'h8001_0001);
    drive_tap(32'h7FFF_FFFF);
    drive_tap(32'h8000_0000);
    drain();

    // zero gap, min above max
    set_config(16'd0, 8'd200, 8'd100, 1'b0);
    drive_tap(32'd5);
    drive_tap(32'd5);
    drive_tap(32'd6);
    drive_tap(32'd6);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 6)
        0:       gap = 16'd2000;
        1:       gap = 16'd1;
        2:       gap = 16'hFFFF;
        3:       gap = 16'($urandom);
        4:       gap = 16'($urandom_range(3000, 300));
        default: gap = 16'd0;
      endcase
      case (p % 5)
        0:       lo = 8'd1;
        1:       lo = 8'd0;
        2:       lo = 8'd255;
        3:       lo = 8'($urandom_range(120, 1));
        default: lo = 8'd40;
      endcase
      case (p % 4)
        0:       hi = 8'd255;
        1:       hi = 8'd1;
        2:       hi = 8'($urandom_range(255, 1));
        default: hi = 8'd240;
      endcase
      set_config(gap, lo, hi, p[0]);
      in_idle  = (p == 1) ? 1'b0 : (p == 2) ? 1'b1 : ($urandom_range(3, 0) != 0);
      out_idle = (p == 1) ? 1'b0 : (p == 2) ? 1'b1 : ($urandom_range(3, 0) != 0);
      t = (p % 3 == 0) ? 32'hFFFF_FFFF - TAP_W'($urandom_range(20000, 0)) : $urandom;
      sent = 0;
      while (sent < TAPS_PER_PHASE) begin
        burst = $urandom_range(8, 1);
        repeat (burst) begin
          drive_tap(t);
          sent++;
          t = t + tap_step();
        end
        // break the history between bursts
        if ($urandom_range(3, 0) == 0) begin
          t = $urandom;
        end else begin
          t = t + TAP_W'(cur_gap) + TAP_W'($urandom_range(3000, 1));
        end
      end
      drain();
    end

    in_idle  = 1'b0;
    out_idle = 1'b0;
    if (pending != 0) $error("%0d tempo results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** tap_tempo_estimator_unit: PASSED **");
    end else begin
      $display("** tap_tempo_estimator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** tap_tempo_estimator_unit: FAILED **");
    $finish;
  end

endmodule
